// File: rtl/grlc_pkg.sv
// shared constants for the gap run locus clusterer
`default_nettype none

package grlc_pkg;

    // parameter defaults
    localparam int MAX_CONTIGS_DEF   = 256;
    localparam int POSITION_BITS_DEF = 40;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int KMER_ID_BITS_DEF  = 24;

    // fixed field widths
    localparam int SLOT_BITS         = 8;
    localparam int GAP_LIMIT_BITS    = 32;
    localparam int MIN_COUNT_BITS    = 16;
    localparam int CONTIG_COUNT_BITS = 9;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GAP_LIMIT    = 2'd0,
        REG_MIN_RUN      = 2'd1,
        REG_CONTIG_COUNT = 2'd2
    } cfg_reg_t;

    localparam logic [GAP_LIMIT_BITS-1:0]    GAP_LIMIT_RST    = 32'd10000;
    localparam logic [MIN_COUNT_BITS-1:0]    MIN_RUN_RST      = 16'd2;
    localparam logic [CONTIG_COUNT_BITS-1:0] CONTIG_COUNT_RST = 9'd1;

    // input command kinds, carried on s_tuser
    localparam logic CMD_LOAD_CONTIG = 1'b0;
    localparam logic CMD_POSITION    = 1'b1;

endpackage

`default_nettype wire

// File: rtl/gap_run_locus_clusterer_unit.sv
// top level of the gap run locus clusterer: contig search, run tracking, locus output
`default_nettype none

// a position request runs a binary search over the first n table slots, n the effective
//   contig count, then updates the run and emits any locus; a contig load is written into the table as it is accepted
// a new request is taken only in idle, after the previous search and its loci are done;
//   the binary search reuses one offset comparator and one table read port
// reset (aresetn low, synchronous): configuration to defaults, run state cleared,
//   no list open, output empty; the contig table is not cleared and holds garbage
module gap_run_locus_clusterer_unit #(
    parameter int MAX_CONTIGS   = grlc_pkg::MAX_CONTIGS_DEF,
    parameter int POSITION_BITS = grlc_pkg::POSITION_BITS_DEF,
    parameter int COUNT_BITS    = grlc_pkg::COUNT_BITS_DEF,
    parameter int KMER_ID_BITS  = grlc_pkg::KMER_ID_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [grlc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [grlc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // request channel
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // low to high: contig_slot, contig_start, position, kmer_id, zero pad
    input  wire logic [((grlc_pkg::SLOT_BITS + 2*POSITION_BITS + KMER_ID_BITS + 7) / 8) * 8 - 1:0]
                                                     s_tdata,
    // command: 0 loads a contig offset, 1 feeds a position
    input  wire logic                                s_tuser,
    // last_position
    input  wire logic                                s_tlast,
    // locus channel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // low to high: locus_start, locus_end, locus_kmer, zero pad
    output logic [((2*POSITION_BITS + KMER_ID_BITS + 7) / 8) * 8 - 1:0]
                                                     m_tdata,
    // last_of_run
    output logic                                     m_tlast
);

    localparam int SB      = grlc_pkg::SLOT_BITS;
    localparam int PB      = POSITION_BITS;
    localparam int KB      = KMER_ID_BITS;
    localparam int OUT_W   = ((2*PB + KB + 7) / 8) * 8;
    // table address and search bound widths
    localparam int AW      = (MAX_CONTIGS > 1) ? $clog2(MAX_CONTIGS) : 1;
    localparam int CW      = $clog2(MAX_CONTIGS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    // request fields
    logic [SB-1:0] in_slot;
    logic [PB-1:0] in_start;
    logic [PB-1:0] in_pos;
    logic [KB-1:0] in_kmer;

    assign in_slot  = s_tdata[SB-1:0];
    assign in_start = s_tdata[SB+PB-1:SB];
    assign in_pos   = s_tdata[SB+2*PB-1:SB+PB];
    assign in_kmer  = s_tdata[SB+2*PB+KB-1:SB+2*PB];

    // configuration
    logic [grlc_pkg::GAP_LIMIT_BITS-1:0]    gap_limit_reg;
    logic [grlc_pkg::MIN_COUNT_BITS-1:0]    min_run_reg;
    logic [grlc_pkg::CONTIG_COUNT_BITS-1:0] contig_count_reg;

    // sequencer and search
    state_t        state_reg, state_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [KB-1:0] kmer_reg, kmer_next;
    logic          last_reg, last_next;

    // run state
    logic [PB-1:0]         run_begin_reg, run_begin_next;
    logic [PB-1:0]         prev_pos_reg, prev_pos_next;
    logic [COUNT_BITS-1:0] run_len_reg, run_len_next;
    logic [AW-1:0]         run_contig_reg, run_contig_next;
    logic                  list_open_reg, list_open_next;

    // output register and one pending locus behind it
    logic          out_valid_reg, out_valid_next;
    logic [PB-1:0] out_start_reg, out_start_next;
    logic [PB-1:0] out_end_reg, out_end_next;
    logic [KB-1:0] out_kmer_reg, out_kmer_next;
    logic          out_last_reg, out_last_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [PB-1:0] pend_start_reg, pend_start_next;
    logic [PB-1:0] pend_end_reg, pend_end_next;

    // contig offset table
    logic [PB-1:0] contig_mem [MAX_CONTIGS];
    logic [PB-1:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;

    logic          in_accept;
    logic [CW-1:0] count_eff;
    logic [CW:0]   mid_sum;
    logic          off_le_pos;
    logic [AW-1:0] found_ctg;
    logic [PB-1:0] gap;
    logic          split;
    logic          emit_split;
    logic          emit_final;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // contig count above the table depth searches the whole table
    assign count_eff = (32'(contig_count_reg) > MAX_CONTIGS) ? CW'(MAX_CONTIGS)
                                                             : CW'(contig_count_reg);

    // the one shared comparator of the search
    assign off_le_pos = (rd_data <= pos_reg);
    // last slot whose offset is not above the position, slot 0 if none is
    assign found_ctg  = (lo_reg == '0) ? '0 : AW'(lo_reg - CW'(1));
    assign gap        = pos_reg - prev_pos_reg;

    // load goes straight into the table
    assign mem_we    = in_accept && (s_tuser == grlc_pkg::CMD_LOAD_CONTIG)
                       && (32'(in_slot) < MAX_CONTIGS);
    assign mem_waddr = AW'(in_slot);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            contig_mem[mem_waddr] <= in_start;
        end
        rd_data <= contig_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_limit_reg    <= grlc_pkg::GAP_LIMIT_RST;
            min_run_reg      <= grlc_pkg::MIN_RUN_RST;
            contig_count_reg <= grlc_pkg::CONTIG_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                grlc_pkg::REG_GAP_LIMIT: begin
                    gap_limit_reg <= cfg_data[grlc_pkg::GAP_LIMIT_BITS-1:0];
                end
                grlc_pkg::REG_MIN_RUN: begin
                    min_run_reg <= cfg_data[grlc_pkg::MIN_COUNT_BITS-1:0];
                end
                grlc_pkg::REG_CONTIG_COUNT: begin
                    contig_count_reg <= cfg_data[grlc_pkg::CONTIG_COUNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pos_next        = pos_reg;
        kmer_next       = kmer_reg;
        last_next       = last_reg;
        run_begin_next  = run_begin_reg;
        prev_pos_next   = prev_pos_reg;
        run_len_next    = run_len_reg;
        run_contig_next = run_contig_reg;
        list_open_next  = list_open_reg;
        out_valid_next  = out_valid_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_kmer_next   = out_kmer_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        mid_sum         = '0;
        split           = 1'b0;
        emit_split      = 1'b0;
        emit_final      = 1'b0;
        rd_addr         = AW'(mid_reg);

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser == grlc_pkg::CMD_POSITION)) begin
                    // open the search interval over the first count_eff slots of the table
                    pos_next   = in_pos;
                    kmer_next  = in_kmer;
                    last_next  = s_tlast;
                    lo_next    = '0;
                    hi_next    = count_eff;
                    mid_sum    = {1'b0, count_eff};
                    mid_next   = CW'(mid_sum >> 1);
                    rd_addr    = AW'(mid_next);
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    // one halving step per cycle, next probe read issued now
                    if (off_le_pos) begin
                        lo_next = mid_reg + CW'(1);
                    end else begin
                        hi_next = mid_reg;
                    end
                    mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
                    mid_next = CW'(mid_sum >> 1);
                    rd_addr  = AW'(mid_next);
                end else begin
                    // contig known: update the run
                    if (!list_open_reg) begin
                        run_begin_next  = pos_reg;
                        run_len_next    = COUNT_BITS'(1);
                        run_contig_next = found_ctg;
                        list_open_next  = 1'b1;
                    end else begin
                        split = (found_ctg != run_contig_reg)
                                || (gap > PB'(gap_limit_reg));
                        if (split) begin
                            emit_split      = 32'(run_len_reg) >= 32'(min_run_reg);
                            run_begin_next  = pos_reg;
                            run_len_next    = COUNT_BITS'(1);
                            run_contig_next = found_ctg;
                        end else if (run_len_reg != COUNT_MAX) begin
                            run_len_next = run_len_reg + COUNT_BITS'(1);
                        end
                    end
                    prev_pos_next = pos_reg;

                    // final position closes whatever run is open
                    if (last_reg) begin
                        emit_final     = 32'(run_len_next) >= 32'(min_run_reg);
                        list_open_next = 1'b0;
                    end

                    out_kmer_next = kmer_reg;
                    if (emit_split) begin
                        out_valid_next  = 1'b1;
                        out_start_next  = run_begin_reg;
                        out_end_next    = prev_pos_reg;
                        out_last_next   = !emit_final;
                        pend_valid_next = emit_final;
                        pend_start_next = run_begin_next;
                        pend_end_next   = pos_reg;
                        state_next      = ST_EMIT;
                    end else if (emit_final) begin
                        out_valid_next  = 1'b1;
                        out_start_next  = run_begin_next;
                        out_end_next    = pos_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT: begin
                if (out_valid_reg && m_tready) begin
                    if (pend_valid_reg) begin
                        // second locus of the same request moves up
                        out_start_next  = pend_start_reg;
                        out_end_next    = pend_end_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end else begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            run_begin_reg  <= '0;
            prev_pos_reg   <= '0;
            run_len_reg    <= '0;
            run_contig_reg <= '0;
            list_open_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            run_begin_reg  <= run_begin_next;
            prev_pos_reg   <= prev_pos_next;
            run_len_reg    <= run_len_next;
            run_contig_reg <= run_contig_next;
            list_open_reg  <= list_open_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        // payload, no reset
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pos_reg        <= pos_next;
        kmer_reg       <= kmer_next;
        last_reg       <= last_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_kmer_reg   <= out_kmer_next;
        out_last_reg   <= out_last_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    // zero pad above the kmer field
    assign m_tdata  = OUT_W'({out_kmer_reg, out_end_reg, out_start_reg});

endmodule

`default_nettype wire
